>>> design/point_in_polygon_orientation_defines.svh
// assertion macros used by the point-in-polygon top level
`ifndef POINT_IN_POLYGON_ORIENTATION_DEFINES_SVH
`define POINT_IN_POLYGON_ORIENTATION_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define PIPO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pipo check failed");

// next-cycle implication, checked on every rising edge out of reset
`define PIPO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pipo check failed");

`endif

>>> design/pipo_pkg.sv
// shared types and constants of the point-in-polygon orientation block
package pipo_pkg;

    localparam int DEF_COORD_BITS = 24;
    localparam int AREA_BITS      = 58;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_TEST_X = 1'b0,
        REG_TEST_Y = 1'b1
    } cfg_reg_t;

    // control that travels with the products into the accumulate stage
    typedef struct packed {
        logic valid;
        logic last;
        logic straddle;
        logic rising;
    } edge_ctl_t;

endpackage

>>> design/pipo_prod.sv
// product stage: differences, cross products and straddle test, registered
module pipo_prod
    import pipo_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          in_last,
    input  logic signed [COORD_BITS-1:0]  sx,
    input  logic signed [COORD_BITS-1:0]  sy,
    input  logic signed [COORD_BITS-1:0]  ex,
    input  logic signed [COORD_BITS-1:0]  ey,
    input  logic signed [COORD_BITS-1:0]  px,
    input  logic signed [COORD_BITS-1:0]  py,
    output edge_ctl_t                     ctl,
    output logic signed [2*COORD_BITS+1:0] lhs,
    output logic signed [2*COORD_BITS+1:0] rhs,
    output logic signed [2*COORD_BITS-1:0] pa,
    output logic signed [2*COORD_BITS-1:0] pb
);

    edge_ctl_t                      ctl_reg, ctl_next;
    logic signed [COORD_BITS:0]     dy_p, dx_e, dx_p, dy_e;
    logic signed [2*COORD_BITS+1:0] lhs_reg, lhs_next, rhs_reg, rhs_next;
    logic signed [2*COORD_BITS-1:0] pa_reg, pa_next, pb_reg, pb_next;

    always_comb begin
        dy_p = (COORD_BITS+1)'(py) - (COORD_BITS+1)'(sy);
        dx_e = (COORD_BITS+1)'(ex) - (COORD_BITS+1)'(sx);
        dx_p = (COORD_BITS+1)'(px) - (COORD_BITS+1)'(sx);
        dy_e = (COORD_BITS+1)'(ey) - (COORD_BITS+1)'(sy);
        lhs_next = (2*COORD_BITS+2)'(dy_p) * (2*COORD_BITS+2)'(dx_e);
        rhs_next = (2*COORD_BITS+2)'(dx_p) * (2*COORD_BITS+2)'(dy_e);
        pa_next  = (2*COORD_BITS)'(sx) * (2*COORD_BITS)'(ey);
        pb_next  = (2*COORD_BITS)'(ex) * (2*COORD_BITS)'(sy);
        ctl_next.valid    = in_valid;
        ctl_next.last     = in_last;
        // half-open: exactly one end strictly below the test y
        ctl_next.straddle = ((sy < py) && (ey >= py)) || ((ey < py) && (sy >= py));
        ctl_next.rising   = (ey > sy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
        end
    end

    assign ctl = ctl_reg;
    assign lhs = lhs_reg;
    assign rhs = rhs_reg;
    assign pa  = pa_reg;
    assign pb  = pb_reg;

endmodule

>>> design/pipo_acc.sv
// accumulate stage: parity toggle, area sum and the result register
module pipo_acc
    import pipo_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  edge_ctl_t                      ctl,
    input  logic signed [2*COORD_BITS+1:0] lhs,
    input  logic signed [2*COORD_BITS+1:0] rhs,
    input  logic signed [2*COORD_BITS-1:0] pa,
    input  logic signed [2*COORD_BITS-1:0] pb,
    input  logic                           res_ready,
    output logic                           fire,
    output logic                           res_valid,
    output logic                           res_inside,
    output logic                           res_clockwise
);

    localparam int TERM_W = 2*COORD_BITS + 1;
    localparam int SUM_W  = (AREA_BITS > TERM_W) ? AREA_BITS : TERM_W;

    logic                    parity_reg, parity_next;
    logic [AREA_BITS-1:0]    area_reg, area_next;
    logic                    valid_reg, valid_next;
    logic                    inside_reg, inside_next;
    logic                    cw_reg, cw_next;
    logic                    out_free, crosses;
    logic signed [TERM_W-1:0] term;
    logic [SUM_W-1:0]        sum;

    always_comb begin
        out_free = !valid_reg || res_ready;
        fire     = ctl.valid && (!ctl.last || out_free);
        crosses  = ctl.straddle && (ctl.rising ? (lhs < rhs) : (lhs > rhs));
        term     = TERM_W'(pa) - TERM_W'(pb);
        sum      = SUM_W'(area_reg) + SUM_W'(term);

        parity_next = parity_reg;
        area_next   = area_reg;
        valid_next  = valid_reg && !res_ready;
        inside_next = inside_reg;
        cw_next     = cw_reg;
        if (fire) begin
            parity_next = parity_reg ^ crosses;
            area_next   = sum[AREA_BITS-1:0];
            if (ctl.last) begin
                valid_next  = 1'b1;
                inside_next = parity_reg ^ crosses;
                cw_next     = sum[AREA_BITS-1];
                parity_next = 1'b0;
                area_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg <= 1'b0;
            area_reg   <= '0;
            valid_reg  <= 1'b0;
        end else begin
            parity_reg <= parity_next;
            area_reg   <= area_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inside_reg <= inside_next;
        cw_reg     <= cw_next;
    end

    assign res_valid     = valid_reg;
    assign res_inside    = inside_reg;
    assign res_clockwise = cw_reg;

endmodule

>>> design/point_in_polygon_orientation.sv
// top level of the point-in-polygon orientation block
//
// s_ channel: one beat per path edge, tdata = from_x, from_y, to_x, to_y
// (lowest first), tlast marks the closing edge of the path.
// cfg channel: index 0 writes test_x, index 1 writes test_y; always ready; the
// user must write only while no edge is in flight (the block does not enforce it).
// m_ channel: one beat per path, sent for the tlast edge only:
// tdata bit 0 = point inside (odd crossings), bit 1 = clockwise (area < 0).
// pipeline: input register, product register (four independent multiplies),
// accumulate plus result register; a final edge passes them in order before it
// shows on m_tvalid, and one edge is taken every cycle unless a stall holds it.
// stalls: non-final edges drain into the accumulator regardless of m_tready;
// only a final edge waits when the result register is still full, and bubbles
// collapse so s_tready drops only when every stage is occupied.
// reset: clears config to zero, parity, area sum and all valid flags.
module point_in_polygon_orientation
    import pipo_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // edge input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata, // from_x, from_y, to_x, to_y
    input  logic                   s_tlast,              // final_edge
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [0:0]             cfg_index,
    input  logic [COORD_BITS-1:0]  cfg_data,
    // path result
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata                // inside_res, clockwise
);

`include "point_in_polygon_orientation_defines.svh"

    // test point
    logic signed [COORD_BITS-1:0] test_x_reg, test_y_reg;

    // input register
    logic                         v1_reg, last1_reg;
    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic                         en1, en2, fire2;

    edge_ctl_t                      ctl2;
    logic signed [2*COORD_BITS+1:0] lhs2, rhs2;
    logic signed [2*COORD_BITS-1:0] pa2, pb2;
    logic                           res_inside, res_cw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            test_x_reg <= '0;
            test_y_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_TEST_X: test_x_reg <= cfg_data;
                REG_TEST_Y: test_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ready chain: a stage loads when it is empty or its content moves on
    assign en2      = !ctl2.valid || fire2;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
    end

    // coordinate fields unpacked lowest first, padding bits ignored
    always_ff @(posedge aclk) begin
        if (en1) begin
            sx_reg    <= s_tdata[0*COORD_BITS +: COORD_BITS];
            sy_reg    <= s_tdata[1*COORD_BITS +: COORD_BITS];
            ex_reg    <= s_tdata[2*COORD_BITS +: COORD_BITS];
            ey_reg    <= s_tdata[3*COORD_BITS +: COORD_BITS];
            last1_reg <= s_tlast;
        end
    end

    pipo_prod #(
        .COORD_BITS (COORD_BITS)
    ) u_prod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en2),
        .in_valid (v1_reg),
        .in_last  (last1_reg),
        .sx       (sx_reg),
        .sy       (sy_reg),
        .ex       (ex_reg),
        .ey       (ey_reg),
        .px       (test_x_reg),
        .py       (test_y_reg),
        .ctl      (ctl2),
        .lhs      (lhs2),
        .rhs      (rhs2),
        .pa       (pa2),
        .pb       (pb2)
    );

    pipo_acc #(
        .COORD_BITS (COORD_BITS)
    ) u_acc (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl2),
        .lhs           (lhs2),
        .rhs           (rhs2),
        .pa            (pa2),
        .pb            (pb2),
        .res_ready     (m_tready),
        .fire          (fire2),
        .res_valid     (m_tvalid),
        .res_inside    (res_inside),
        .res_clockwise (res_cw)
    );

    assign m_tdata = {6'b0, res_cw, res_inside};

    // input side only stalls when a finished result is blocked downstream
    `PIPO_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)
    // a result appears only from a final edge in the accumulate stage
    `PIPO_ASSERT_NEXT(a_result_source, !m_tvalid && !(ctl2.valid && ctl2.last), !m_tvalid)
    // an edge in the input register moves to the product stage when it is free
    `PIPO_ASSERT_NEXT(a_stage_advance, v1_reg && en2, ctl2.valid)

endmodule
